[src/pfc_pkg.sv]
// Shared constants and types for the prime factor counter.
`timescale 1ns / 1ps

package pfc_pkg;

  // Primes are sieved below this bound; its square must exceed every input value
  localparam int SIEVE_LIMIT = 65536;
  localparam int VALUE_BITS  = 31;
  localparam int COUNT_W     = 5;

  // Width of a sieve candidate, a table prime and a composite-mark address
  localparam int PRIME_W     = $clog2(SIEVE_LIMIT);
  // Number of primes below SIEVE_LIMIT
  localparam int PRIME_DEPTH = 6542;
  localparam int PIDX_W      = $clog2(PRIME_DEPTH);
  localparam int PCNT_W      = $clog2(PRIME_DEPTH + 1);
  localparam int SQ_W        = 2 * PRIME_W;
  localparam int DSTEP_W     = $clog2(VALUE_BITS);

  // Prime stream from the sieve into the prime table
  typedef struct packed {
    logic               wr;
    logic [PRIME_W-1:0] prime;
    logic               done;
  } sieve_out_t;

endpackage

[src/pfc_sieve.sv]
// Clearing pass and Eratosthenes sieve that streams out the primes in ascending order.
`timescale 1ns / 1ps

module pfc_sieve (
  input  logic               clk,
  input  logic               rst_n,
  output pfc_pkg::sieve_out_t sieve_o
);
  import pfc_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_READ  = 5'b00010,
    S_TEST  = 5'b00100,
    S_MARK  = 5'b01000,
    S_DONE  = 5'b10000
  } sieve_state_t;

  localparam logic [PRIME_W-1:0] K_LAST = PRIME_W'(SIEVE_LIMIT - 1);
  localparam logic [PRIME_W:0]   M_END  = (PRIME_W + 1)'(SIEVE_LIMIT);

  sieve_state_t       state_r, state_nxt;
  logic [PRIME_W-1:0] clr_r;
  logic [PRIME_W-1:0] k_r;
  logic [PRIME_W:0]   m_r;
  logic               mark_q;
  logic               mark_mem [SIEVE_LIMIT];
  logic               m_in;

  assign m_in = (m_r < M_END);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (clr_r == K_LAST) state_nxt = S_READ;
      S_READ:  state_nxt = S_TEST;
      S_TEST: begin
        if (!mark_q) state_nxt = S_MARK;
        else if (k_r == K_LAST) state_nxt = S_DONE;
        else state_nxt = S_READ;
      end
      S_MARK: begin
        if (!m_in) state_nxt = (k_r == K_LAST) ? S_DONE : S_READ;
      end
      S_DONE:  state_nxt = S_DONE;
      default: state_nxt = S_CLEAR;
    endcase
  end

  // Mark memory: one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (state_r == S_CLEAR) begin
      mark_mem[clr_r] <= 1'b0;
    end else if (state_r == S_MARK && m_in) begin
      mark_mem[m_r[PRIME_W-1:0]] <= 1'b1;
    end
    mark_q <= mark_mem[k_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      k_r     <= PRIME_W'(2);
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) clr_r <= clr_r + PRIME_W'(1);
      if (state_r == S_TEST && mark_q) k_r <= k_r + PRIME_W'(1);
      if (state_r == S_MARK && !m_in) k_r <= k_r + PRIME_W'(1);
    end
  end

  // Start striking out multiples from twice the prime
  always_ff @(posedge clk) begin
    if (state_r == S_TEST) begin
      m_r <= {1'b0, k_r} + {1'b0, k_r};
    end else if (state_r == S_MARK && m_in) begin
      m_r <= m_r + {1'b0, k_r};
    end
  end

  assign sieve_o.wr    = (state_r == S_TEST) && !mark_q;
  assign sieve_o.prime = k_r;
  assign sieve_o.done  = (state_r == S_DONE);

endmodule

[src/pfc_div.sv]
// Bit-serial restoring divider: one quotient bit a cycle.
`timescale 1ns / 1ps

module pfc_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [pfc_pkg::VALUE_BITS-1:0] dividend,
  input  logic [pfc_pkg::PRIME_W-1:0]    divisor,
  output logic                           done,
  output logic                           rem_zero,
  output logic [pfc_pkg::VALUE_BITS-1:0] quotient
);
  import pfc_pkg::*;

  localparam logic [DSTEP_W-1:0] STEP_LAST = DSTEP_W'(VALUE_BITS - 1);

  logic                  busy_r;
  logic                  done_r;
  logic [DSTEP_W-1:0]    step_r;
  logic [PRIME_W-1:0]    rem_r;
  logic [PRIME_W-1:0]    dsr_r;
  logic [VALUE_BITS-1:0] quo_r;
  logic [PRIME_W:0]      acc;
  logic [PRIME_W:0]      diff;
  logic                  ge;

  assign acc  = {rem_r, quo_r[VALUE_BITS-1]};
  assign ge   = (acc >= {1'b0, dsr_r});
  assign diff = acc - {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && step_r == STEP_LAST) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= '0;
      quo_r  <= dividend;
      dsr_r  <= divisor;
      step_r <= '0;
    end else if (busy_r) begin
      rem_r  <= ge ? diff[PRIME_W-1:0] : acc[PRIME_W-1:0];
      quo_r  <= {quo_r[VALUE_BITS-2:0], ge};
      step_r <= step_r + DSTEP_W'(1);
    end
  end

  assign done     = done_r;
  assign rem_zero = (rem_r == '0);
  assign quotient = quo_r;

endmodule

[src/prime_factor_count.sv]
// Top level: prime table, trial-division sequencer and result register.
`timescale 1ns / 1ps

// Counts the prime factors of a positive integer, repeated factors included.
// Input channel: in_valid / in_stall / in_value. A request is taken when
// in_valid is high and in_stall low; in_stall stays high while a request is
// being factored and while the prime table is still being built.
// Result channel: out_valid / out_stall / out_factor_count, one result per
// request, in order. The result register holds while out_stall is high; a new
// request may be taken while the previous result still waits.
// Reset (rst_n low, synchronous) clears the controllers and starts the table
// build: a clearing pass over all 65536 entries of the mark memory, then the
// sieve, which scans every candidate and marks the multiples of each prime.
// Requests are refused until the build is done; it is done once per reset.
// Every prime tried costs one division in the bit-serial divider, which forms
// the 31 quotient bits one at a time, plus table read, square and compare.
// Each factor found costs one more division.
// Trial stops when the square of the next prime exceeds the working value, so
// the time for an input n grows with the number of primes up to max(its
// second-largest prime factor, sqrt of its largest); zero skips the trial.

module prime_factor_count (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [pfc_pkg::VALUE_BITS-1:0] in_value,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [pfc_pkg::COUNT_W-1:0]    out_factor_count
);
  import pfc_pkg::*;

  typedef enum logic [6:0] {
    T_IDLE  = 7'b0000001,
    T_FETCH = 7'b0000010,
    T_LOAD  = 7'b0000100,
    T_CMP   = 7'b0001000,
    T_DIV   = 7'b0010000,
    T_LEFT  = 7'b0100000,
    T_OUT   = 7'b1000000
  } trial_state_t;

  localparam logic [VALUE_BITS-1:0] ONE = VALUE_BITS'(1);

  trial_state_t          state_r, state_nxt;
  sieve_out_t            sieve;
  logic [PRIME_W-1:0]    prime_mem [PRIME_DEPTH];
  logic [PCNT_W-1:0]     prime_cnt_r;
  logic [PCNT_W-1:0]     idx_r;
  logic [PRIME_W-1:0]    p_q;
  logic [PRIME_W-1:0]    p_r;
  logic [SQ_W-1:0]       sq_r;
  logic [VALUE_BITS-1:0] n_r;
  logic [COUNT_W-1:0]    cnt_r;
  logic                  out_valid_r;
  logic [COUNT_W-1:0]    out_cnt_r;
  logic                  in_accept;
  logic                  out_free;
  logic                  sq_over;
  logic                  div_start;
  logic                  div_done;
  logic                  div_rem_zero;
  logic [VALUE_BITS-1:0] div_quo;

  pfc_sieve u_sieve (
    .clk     (clk),
    .rst_n   (rst_n),
    .sieve_o (sieve)
  );

  pfc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (n_r),
    .divisor  (p_r),
    .done     (div_done),
    .rem_zero (div_rem_zero),
    .quotient (div_quo)
  );

  assign in_stall  = !(state_r == T_IDLE && sieve.done);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  // Once p*p exceeds the working value, what is left is one or a prime
  assign sq_over   = (sq_r > SQ_W'(n_r));
  assign div_start = (state_r == T_CMP) && !sq_over;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      T_IDLE:  if (in_accept) state_nxt = (in_value == '0) ? T_OUT : T_FETCH;
      T_FETCH: state_nxt = (idx_r == prime_cnt_r) ? T_LEFT : T_LOAD;
      T_LOAD:  state_nxt = T_CMP;
      T_CMP:   state_nxt = sq_over ? T_LEFT : T_DIV;
      T_DIV:   if (div_done) state_nxt = div_rem_zero ? T_CMP : T_FETCH;
      T_LEFT:  state_nxt = T_OUT;
      T_OUT:   if (out_free) state_nxt = T_IDLE;
      default: state_nxt = T_IDLE;
    endcase
  end

  // Prime table: filled by the sieve, read once per prime tried
  always_ff @(posedge clk) begin
    if (sieve.wr && prime_cnt_r < PCNT_W'(PRIME_DEPTH)) begin
      prime_mem[prime_cnt_r[PIDX_W-1:0]] <= sieve.prime;
    end
    p_q <= prime_mem[idx_r[PIDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_IDLE;
      prime_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (sieve.wr && prime_cnt_r < PCNT_W'(PRIME_DEPTH)) begin
        prime_cnt_r <= prime_cnt_r + PCNT_W'(1);
      end
      // Load a new result when the register is free; else drop the one taken
      if (state_r == T_OUT && out_free) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // Working value, factor count, prime index, trial prime and its square, result
  always_ff @(posedge clk) begin
    unique case (state_r)
      T_IDLE: begin
        if (in_accept) begin
          n_r   <= in_value;
          cnt_r <= '0;
          idx_r <= '0;
        end
      end
      T_LOAD: begin
        p_r  <= p_q;
        sq_r <= SQ_W'(p_q) * SQ_W'(p_q);
      end
      T_DIV: begin
        if (div_done) begin
          if (div_rem_zero) begin
            n_r   <= div_quo;
            cnt_r <= cnt_r + COUNT_W'(1);
          end else begin
            idx_r <= idx_r + PCNT_W'(1);
          end
        end
      end
      T_LEFT: begin
        if (n_r != ONE) cnt_r <= cnt_r + COUNT_W'(1);
      end
      T_OUT: begin
        if (out_free) out_cnt_r <= cnt_r;
      end
      default: begin
      end
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_factor_count = out_cnt_r;

endmodule
